// ===== design/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assertion macros
// concurrent checks clocked on the rising edge, with or without reset gating
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check that is switched off while reset is high
`define CHECK_RST(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// check that also holds across reset
`define CHECK_ANY(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== design/tsrr_pkg.sv =====
// ----------------------------------------------------------------------------
// tsrr_pkg
// shared types and codes of the trie shortest root replacer
// ----------------------------------------------------------------------------
`default_nettype none

package tsrr_pkg;

  localparam int LETTER_W = 5;

  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  typedef struct packed {
    logic [LETTER_W-1:0] out_letter;
    logic                word_end;
    logic                dictionary_full;
  } result_t;

  typedef struct packed {
    logic clearing;
    logic overflow;
  } status_t;

endpackage

`default_nettype wire

// ===== design/tsrr_in_if.sv =====
// ----------------------------------------------------------------------------
// tsrr_in_if
// input channel: one root or sentence letter per word
// ----------------------------------------------------------------------------
`default_nettype none

interface tsrr_in_if import tsrr_pkg::*; ();
  logic                valid;
  logic                ready;
  logic                operation;
  logic [LETTER_W-1:0] letter;
  logic                last;

  modport source (output valid, output operation, output letter, output last,
                  input ready);
  modport sink (input valid, input operation, input letter, input last,
                output ready);
endinterface

`default_nettype wire

// ===== design/tsrr_out_if.sv =====
// ----------------------------------------------------------------------------
// tsrr_out_if
// output channel: one letter of the replaced sentence per word
// ----------------------------------------------------------------------------
`default_nettype none

interface tsrr_out_if import tsrr_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [LETTER_W-1:0] out_letter;
  logic                word_end;
  logic                dictionary_full;

  modport source (output valid, output out_letter, output word_end,
                  output dictionary_full, input ready);
  modport sink (input valid, input out_letter, input word_end,
                input dictionary_full, output ready);
endinterface

`default_nettype wire

// ===== design/trie_shortest_root_replacer.sv =====
// ----------------------------------------------------------------------------
// trie_shortest_root_replacer
// replaces each sentence word by its shortest dictionary root, letter by letter
//
// item channel: operation 0 streams the letters of one dictionary root, with
// last on its final letter; operation 1 streams the letters of a sentence word.
// result channel: one word per echoed sentence letter, word_end on the letter
// that closes the output word, dictionary_full sticky once the node pool ran out.
// every letter does one child table read; the read data feeds the next
// address directly, so an item is taken every cycle when the result side
// keeps up; a result passes through the child table read register and then
// the output register. root letters give no result.
// after reset the child table is swept to zero, all NODE_COUNT * ALPHABET_SIZE
// entries (26624 by default), with item.ready low.
// when the receiver stalls the output register holds; one more letter may be
// looked up and waits until the register frees, then the input side stalls.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module trie_shortest_root_replacer import tsrr_pkg::*; #(
  parameter int NODE_COUNT    = 1024,
  parameter int ALPHABET_SIZE = 26
) (
  input  wire logic clk,
  input  wire logic rst,
  tsrr_in_if.sink   item,
  tsrr_out_if.source result
);

  localparam int IDX_W  = $clog2(NODE_COUNT);
  localparam int DEPTH  = NODE_COUNT * ALPHABET_SIZE;
  localparam int SLOT_W = $clog2(DEPTH);

  logic              ram_we;
  logic [SLOT_W-1:0] ram_waddr;
  logic [IDX_W:0]    ram_wdata;
  logic              ram_re;
  logic [SLOT_W-1:0] ram_raddr;
  logic [IDX_W:0]    ram_rdata;
  logic              res_valid;
  result_t           res;
  logic              res_ready;
  status_t           stat;

  logic              out_valid;
  result_t           out_word;

  tsrr_ctrl #(
    .NODE_COUNT    (NODE_COUNT),
    .ALPHABET_SIZE (ALPHABET_SIZE),
    .IDX_W         (IDX_W),
    .SLOT_W        (SLOT_W),
    .DEPTH         (DEPTH)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .item      (item),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_re    (ram_re),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata),
    .res_valid (res_valid),
    .res       (res),
    .res_ready (res_ready),
    .stat      (stat)
  );

  tsrr_node_ram #(
    .DEPTH  (DEPTH),
    .ADDR_W (SLOT_W),
    .DATA_W (IDX_W + 1)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // output register
  assign res_ready = !out_valid || result.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_ready) begin
      out_valid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_word <= res;
    end
  end

  assign result.valid           = out_valid;
  assign result.out_letter      = out_word.out_letter;
  assign result.word_end        = out_word.word_end;
  assign result.dictionary_full = out_word.dictionary_full;

  `CHECK_RST(a_res_hold, clk, rst, res_valid && !res_ready |=> res_valid, "result lost in stall")
  `CHECK_RST(a_full_sticky, clk, rst, stat.overflow |=> stat.overflow, "overflow flag cleared")
  `CHECK_ANY(a_clear_after_rst, clk, rst |=> stat.clearing, "no clearing sweep after reset")
  `CHECK_RST(a_no_take_clear, clk, rst, stat.clearing |-> !item.ready, "item taken during sweep")

endmodule

`default_nettype wire

// ===== design/tsrr_node_ram.sv =====
// ----------------------------------------------------------------------------
// tsrr_node_ram
// child table: one write port, one registered read port, write-first bypass
// ----------------------------------------------------------------------------
`default_nettype none

module tsrr_node_ram #(
  parameter int DEPTH  = 26624,
  parameter int ADDR_W = 15,
  parameter int DATA_W = 11
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [ADDR_W-1:0] waddr,
  input  wire logic [DATA_W-1:0] wdata,
  input  wire logic              re,
  input  wire logic [ADDR_W-1:0] raddr,
  output logic      [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      if (we && (waddr == raddr)) begin
        rdata <= wdata;
      end else begin
        rdata <= mem[raddr];
      end
    end
  end

endmodule

`default_nettype wire

// ===== design/tsrr_ctrl.sv =====
// ----------------------------------------------------------------------------
// tsrr_ctrl
// sequencer: clearing sweep, child table lookup, insert and match decisions
// ----------------------------------------------------------------------------
`default_nettype none

module tsrr_ctrl import tsrr_pkg::*; #(
  parameter int NODE_COUNT    = 1024,
  parameter int ALPHABET_SIZE = 26,
  parameter int IDX_W         = 10,
  parameter int SLOT_W        = 15,
  parameter int DEPTH         = 26624
) (
  input  wire logic              clk,
  input  wire logic              rst,
  tsrr_in_if.sink                item,
  output logic                   ram_we,
  output logic [SLOT_W-1:0]      ram_waddr,
  output logic [IDX_W:0]         ram_wdata,
  output logic                   ram_re,
  output logic [SLOT_W-1:0]      ram_raddr,
  input  wire logic [IDX_W:0]    ram_rdata,
  output logic                   res_valid,
  output result_t                res,
  input  wire logic              res_ready,
  output status_t                stat
);

  typedef enum logic [2:0] {
    S_CLEAR = 3'b001,
    S_IDLE  = 3'b010,
    S_LOOK  = 3'b100
  } state_t;

  typedef enum logic [2:0] {
    MODE_MATCHING    = 3'b001,
    MODE_PASSING     = 3'b010,
    MODE_SUPPRESSING = 3'b100
  } mode_t;

  state_t              state, state_next;
  logic [SLOT_W-1:0]   clr_addr;
  logic                op_q;
  logic [LETTER_W-1:0] letter_q;
  logic                last_q;
  logic [SLOT_W-1:0]   slot_q;

  logic [IDX_W:0]      next_free, next_free_next;
  logic [IDX_W-1:0]    load_cursor, load_cursor_next;
  logic [IDX_W-1:0]    match_cursor, match_cursor_next;
  mode_t               match_mode, match_mode_next;
  logic                overflow_seen, overflow_seen_next;
  logic                load_dropped, load_dropped_next;

  logic                in_fire;
  logic                clr_done;
  logic                q_in_range;
  logic                rd_term;
  logic [IDX_W-1:0]    rd_node;
  logic [IDX_W-1:0]    hit_node;
  logic                has_free;
  logic                emit;
  logic                end_flag;
  logic                look_we;
  logic [IDX_W:0]      look_wdata;
  logic                look_done;
  logic                look_commit;
  logic [IDX_W-1:0]    addr_cursor;
  logic [LETTER_W-1:0] addr_letter;

  assign clr_done   = (clr_addr == SLOT_W'(DEPTH - 1));
  assign q_in_range = (int'(letter_q) < ALPHABET_SIZE);
  assign rd_term    = ram_rdata[IDX_W];
  assign rd_node    = ram_rdata[IDX_W-1:0];
  assign hit_node   = q_in_range ? rd_node : '0;
  assign has_free   = (next_free < (IDX_W+1)'(NODE_COUNT));

  // decision on the looked-up child entry
  always_comb begin
    next_free_next     = next_free;
    load_cursor_next   = load_cursor;
    match_cursor_next  = match_cursor;
    match_mode_next    = match_mode;
    overflow_seen_next = overflow_seen;
    load_dropped_next  = load_dropped;
    emit               = 1'b0;
    end_flag           = last_q;
    look_we            = 1'b0;
    look_wdata         = '0;
    if (state == S_LOOK) begin
      if (op_q == OP_LOAD) begin
        if (!load_dropped) begin
          priority if (!q_in_range) begin
            load_dropped_next = 1'b1;
          end else if (rd_node == '0) begin
            if (has_free) begin
              look_we          = 1'b1;
              look_wdata       = {last_q, next_free[IDX_W-1:0]};
              load_cursor_next = next_free[IDX_W-1:0];
              next_free_next   = next_free + 1'b1;
            end else begin
              overflow_seen_next = 1'b1;
              load_dropped_next  = 1'b1;
            end
          end else begin
            load_cursor_next = rd_node;
            if (last_q) begin
              look_we    = 1'b1;
              look_wdata = {1'b1, rd_node};
            end
          end
        end
        if (last_q) begin
          load_cursor_next  = '0;
          load_dropped_next = 1'b0;
        end
      end else begin
        unique case (match_mode)
          MODE_MATCHING: begin
            emit = 1'b1;
            if (hit_node == '0) begin
              match_mode_next = MODE_PASSING;
            end else begin
              match_cursor_next = hit_node;
              if (rd_term) begin
                end_flag        = 1'b1;
                match_mode_next = MODE_SUPPRESSING;
              end
            end
          end
          MODE_PASSING: begin
            emit = 1'b1;
          end
          MODE_SUPPRESSING: begin
            emit = 1'b0;
          end
          default: begin
            emit = 1'b0;
          end
        endcase
        if (last_q) begin
          match_cursor_next = '0;
          match_mode_next   = MODE_MATCHING;
        end
      end
    end
  end

  assign look_done   = !emit || res_ready;
  assign look_commit = (state == S_LOOK) && look_done;

  assign item.ready = (state == S_IDLE) || look_commit;
  assign in_fire    = item.valid && item.ready;

  // next lookup address uses the cursors as updated by the item in flight
  assign addr_cursor = (item.operation == OP_LOAD) ? load_cursor_next : match_cursor_next;
  assign addr_letter = (int'(item.letter) < ALPHABET_SIZE) ? item.letter : '0;
  assign ram_re      = in_fire;
  assign ram_raddr   = SLOT_W'(SLOT_W'(addr_cursor) * SLOT_W'(ALPHABET_SIZE)
                       + SLOT_W'(addr_letter));

  always_comb begin
    if (state == S_CLEAR) begin
      ram_we    = 1'b1;
      ram_waddr = clr_addr;
      ram_wdata = '0;
    end else begin
      ram_we    = look_we && look_commit;
      ram_waddr = slot_q;
      ram_wdata = look_wdata;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_CLEAR: begin
        if (clr_done) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_fire) begin
          state_next = S_LOOK;
        end
      end
      S_LOOK: begin
        if (look_done) begin
          state_next = in_fire ? S_LOOK : S_IDLE;
        end
      end
      default: begin
        state_next = S_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_CLEAR;
      clr_addr      <= '0;
      next_free     <= (IDX_W+1)'(1);
      load_cursor   <= '0;
      match_cursor  <= '0;
      match_mode    <= MODE_MATCHING;
      overflow_seen <= 1'b0;
      load_dropped  <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_CLEAR) begin
        clr_addr <= clr_addr + 1'b1;
      end
      if (look_commit) begin
        next_free     <= next_free_next;
        load_cursor   <= load_cursor_next;
        match_cursor  <= match_cursor_next;
        match_mode    <= match_mode_next;
        overflow_seen <= overflow_seen_next;
        load_dropped  <= load_dropped_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      op_q     <= item.operation;
      letter_q <= item.letter;
      last_q   <= item.last;
      slot_q   <= ram_raddr;
    end
  end

  assign res_valid           = (state == S_LOOK) && emit;
  assign res.out_letter      = letter_q;
  assign res.word_end        = end_flag;
  assign res.dictionary_full = overflow_seen;

  assign stat.clearing = (state == S_CLEAR);
  assign stat.overflow = overflow_seen;

endmodule

`default_nettype wire

// ===== dv/tb_trie_shortest_root_replacer.sv =====
// ----------------------------------------------------------------------------
// tb_trie_shortest_root_replacer
// self-checking bench: streams dictionary roots and sentence words with random
// gaps and result-side stalls, fills the node pool until roots are dropped,
// and compares every result word against a trie kept inside the bench
// ----------------------------------------------------------------------------
`default_nettype none

module tb_trie_shortest_root_replacer;
  import tsrr_pkg::*;

  localparam int NODES = 1024;
  localparam int ALPHA = 26;
  localparam int QUIET_LIMIT = 100000;
  localparam int MAX_ROOTS = 80;

  typedef enum logic [1:0] {WALK_MATCH, WALK_PASS, WALK_SKIP} walk_mode_t;

  typedef struct packed {
    logic                op;
    logic [LETTER_W-1:0] letter;
    logic                last;
  } trie_letter_t;

  typedef struct packed {
    logic [15:0][LETTER_W-1:0] chars;
    logic [4:0]                len;
  } root_rec_t;

  logic clk;
  logic rst;

  tsrr_in_if  item_ch ();
  tsrr_out_if result_ch ();

  trie_shortest_root_replacer #(
    .NODE_COUNT   (NODES),
    .ALPHABET_SIZE(ALPHA)
  ) u_dut (
    .clk   (clk),
    .rst   (rst),
    .item  (item_ch),
    .result(result_ch)
  );

  // bench copy of the trie
  bit [9:0]   kids [NODES*ALPHA];
  bit         terminal [NODES];
  int         pool_next = 1;
  int         load_node = 0;
  int         match_node = 0;
  bit         load_dropped = 0;
  bit         overflow = 0;
  walk_mode_t walk = WALK_MATCH;

  trie_letter_t pending[$];
  result_t      replaced_letters[$];
  root_rec_t    roots_known[$];

  int letters_queued = 0;
  int letters_taken = 0;
  int results_seen = 0;
  int errors = 0;
  int cyc = 0;
  int send_gap = 0;
  int stall_left = 0;
  int hold_left = 0;
  int quiet_cycles = 0;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic int idle_len();
    int roll;
    roll = $urandom_range(0, 99);
    if (((cyc >> 9) % 4) == 1) return 0;
    if (roll < 70) return 0;
    if (roll < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic follow_trie(input trie_letter_t it);
    int      slot;
    int      nxt;
    bit      emit;
    result_t r;
    nxt = 0;
    emit = 1'b0;
    r.out_letter = it.letter;
    r.word_end = it.last;
    if (it.op == OP_LOAD) begin
      if (!load_dropped) begin
        if (it.letter >= ALPHA) begin
          load_dropped = 1'b1;
        end else begin
          slot = load_node * ALPHA + it.letter;
          nxt = kids[slot];
          if (nxt == 0) begin
            if (pool_next < NODES) begin
              nxt = pool_next;
              pool_next++;
              kids[slot] = 10'(nxt);
            end else begin
              overflow = 1'b1;
              load_dropped = 1'b1;
            end
          end
          if (!load_dropped) begin
            load_node = nxt;
            if (it.last) terminal[nxt] = 1'b1;
          end
        end
      end
      if (it.last) begin
        load_node = 0;
        load_dropped = 1'b0;
      end
    end else begin
      if (walk == WALK_MATCH) begin
        if (it.letter < ALPHA) nxt = kids[match_node * ALPHA + it.letter];
        emit = 1'b1;
        if (nxt == 0) begin
          walk = WALK_PASS;
        end else begin
          match_node = nxt;
          if (terminal[nxt]) begin
            r.word_end = 1'b1;
            walk = WALK_SKIP;
          end
        end
      end else if (walk == WALK_PASS) begin
        emit = 1'b1;
      end
      if (it.last) begin
        match_node = 0;
        walk = WALK_MATCH;
      end
      r.dictionary_full = overflow;
      if (emit) replaced_letters.push_back(r);
    end
  endtask

  task automatic note_mismatch(input string what, input int want, input int got);
    errors++;
    $display("%0t: %s mismatch: expected %0d, got %0d", $time, what, want, got);
  endtask

  // driver
  always @(posedge clk) begin
    trie_letter_t seen;
    trie_letter_t nxt_item;
    if (rst) begin
      item_ch.valid <= 1'b0;
      item_ch.operation <= OP_LOAD;
      item_ch.letter <= '0;
      item_ch.last <= 1'b0;
    end else begin
      if (item_ch.valid && item_ch.ready) begin
        seen.op = item_ch.operation;
        seen.letter = item_ch.letter;
        seen.last = item_ch.last;
        follow_trie(seen);
        letters_taken++;
      end
      if (!item_ch.valid || item_ch.ready) begin
        if (send_gap > 0) begin
          send_gap--;
          item_ch.valid <= 1'b0;
        end else if (pending.size() > 0) begin
          nxt_item = pending.pop_front();
          item_ch.valid <= 1'b1;
          item_ch.operation <= nxt_item.op;
          item_ch.letter <= nxt_item.letter;
          item_ch.last <= nxt_item.last;
          send_gap = idle_len();
        end else begin
          item_ch.valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    result_t want;
    if (rst) begin
      result_ch.ready <= 1'b0;
    end else begin
      if (result_ch.valid && result_ch.ready) begin
        results_seen++;
        if (results_seen == 40) hold_left = 500;
        if (replaced_letters.size() == 0) begin
          errors++;
          $display("%0t: unexpected result: expected none, got letter %0d word_end %0d full %0d",
                   $time, result_ch.out_letter, result_ch.word_end,
                   result_ch.dictionary_full);
        end else begin
          want = replaced_letters.pop_front();
          if (result_ch.out_letter !== want.out_letter)
            note_mismatch("out_letter", int'(want.out_letter), int'(result_ch.out_letter));
          if (result_ch.word_end !== want.word_end)
            note_mismatch("word_end", int'(want.word_end), int'(result_ch.word_end));
          if (result_ch.dictionary_full !== want.dictionary_full)
            note_mismatch("dictionary_full", int'(want.dictionary_full),
                          int'(result_ch.dictionary_full));
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        result_ch.ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        result_ch.ready <= 1'b0;
      end else begin
        stall_left = idle_len();
        result_ch.ready <= (stall_left == 0);
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cyc <= cyc + 1;
    if (rst || (item_ch.valid && item_ch.ready) || (result_ch.valid && result_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic push_letter(input logic op, input int letter, input logic last);
    trie_letter_t it;
    it.op = op;
    it.letter = LETTER_W'(letter);
    it.last = last;
    pending.push_back(it);
    letters_queued++;
  endtask

  task automatic load_root(input int len, input bit allow_bad);
    root_rec_t rr;
    int        bad_at;
    bad_at = (allow_bad && $urandom_range(0, 9) == 0) ? $urandom_range(0, len - 1) : -1;
    rr.chars = '0;
    rr.len = 5'(len);
    for (int i = 0; i < len; i++) begin
      rr.chars[i] = (i == bad_at) ? LETTER_W'($urandom_range(26, 31))
                                  : LETTER_W'($urandom_range(0, ALPHA - 1));
      push_letter(OP_LOAD, int'(rr.chars[i]), i == len - 1);
    end
    if (bad_at < 0) begin
      if (roots_known.size() < MAX_ROOTS) roots_known.push_back(rr);
      else roots_known[$urandom_range(0, MAX_ROOTS - 1)] = rr;
    end
  endtask

  task automatic send_word();
    logic [LETTER_W-1:0] w [24];
    root_rec_t           rr;
    int                  n;
    int                  roll;
    roll = $urandom_range(0, 99);
    if (roll < 55 && roots_known.size() > 0) begin
      rr = roots_known[$urandom_range(0, roots_known.size() - 1)];
      n = int'(rr.len);
      for (int i = 0; i < 16; i++) w[i] = rr.chars[i];
      case ($urandom_range(0, 3))
        1: begin
          for (int i = 0; i < $urandom_range(1, 5); i++) begin
            w[n] = LETTER_W'($urandom_range(0, ALPHA - 1));
            n++;
          end
        end
        2: n = int'($urandom_range(1, n));
        3: w[$urandom_range(0, n - 1)] = LETTER_W'($urandom_range(0, ALPHA - 1));
        default: ;
      endcase
    end else if (roll < 95) begin
      n = int'($urandom_range(1, 8));
      for (int i = 0; i < n; i++) w[i] = LETTER_W'($urandom_range(0, ALPHA - 1));
    end else begin
      n = int'($urandom_range(1, 6));
      for (int i = 0; i < n; i++) w[i] = LETTER_W'($urandom_range(0, 31));
    end
    for (int i = 0; i < n; i++) push_letter(OP_QUERY, int'(w[i]), i == n - 1);
  endtask

  task automatic mixed_traffic(input int count);
    int target;
    target = letters_queued + count;
    while (letters_queued < target) begin
      if ($urandom_range(0, 99) < 30) load_root($urandom_range(1, 6), 1'b1);
      else send_word();
    end
  endtask

  task automatic drain();
    while (letters_taken != letters_queued || replaced_letters.size() != 0) @(negedge clk);
  endtask

  initial begin
    rst = 1'b1;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // empty dictionary, then roots "ab", a dropped bad root, "z"
    push_letter(OP_QUERY, 0, 1'b1);
    push_letter(OP_LOAD, 0, 1'b0);
    push_letter(OP_LOAD, 1, 1'b1);
    push_letter(OP_LOAD, 31, 1'b0);
    push_letter(OP_LOAD, 2, 1'b1);
    push_letter(OP_LOAD, 25, 1'b1);
    // shortest root wins, rest of word suppressed
    push_letter(OP_QUERY, 0, 1'b0);
    push_letter(OP_QUERY, 1, 1'b0);
    push_letter(OP_QUERY, 2, 1'b1);
    // word ends inside the trie
    push_letter(OP_QUERY, 0, 1'b1);
    // root hit on first letter, last letter suppressed
    push_letter(OP_QUERY, 25, 1'b0);
    push_letter(OP_QUERY, 25, 1'b1);
    // missing child then bad letter passes through
    push_letter(OP_QUERY, 16, 1'b0);
    push_letter(OP_QUERY, 31, 1'b1);
    push_letter(OP_QUERY, 31, 1'b0);
    push_letter(OP_QUERY, 30, 1'b1);
    push_letter(OP_QUERY, 1, 1'b0);
    push_letter(OP_QUERY, 0, 1'b1);
    // longer root behind a shorter one
    push_letter(OP_LOAD, 0, 1'b0);
    push_letter(OP_LOAD, 1, 1'b0);
    push_letter(OP_LOAD, 3, 1'b1);
    push_letter(OP_QUERY, 0, 1'b0);
    push_letter(OP_QUERY, 1, 1'b0);
    push_letter(OP_QUERY, 3, 1'b1);
    drain();

    mixed_traffic(150);
    drain();
    repeat (30) @(negedge clk);

    // fill the node pool
    while (pool_next < NODES) begin
      repeat (8) load_root($urandom_range(8, 16), 1'b0);
      repeat (3) send_word();
      drain();
    end
    repeat (6) load_root($urandom_range(3, 10), 1'b0);

    mixed_traffic(150);
    drain();
    repeat (20) @(negedge clk);

    if (replaced_letters.size() != 0) begin
      errors++;
      $display("%0t: %0d expected results never arrived", $time, replaced_letters.size());
    end
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire
